/* sv/ptwi_pkg.sv */
`timescale 1ns / 1ps

package ptwi_pkg;

  typedef struct packed {
    logic signed [19:0] ang_rate;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [19:0] heading;
    logic               clipped;
  } out_word_t;

  typedef struct packed {
    logic     zone;
    in_word_t tw;
  } ctx_t;

  localparam int QUO_W = 33;

  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic        [33:0] Q30_TWO_PI  = 34'd6746518852;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [QUO_W-1:0] POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0] NEG_LIM = 33'h0_8000_0000;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > Q30_ONE) begin
      r = 32'sd1073741824;
    end else if (v < -Q30_ONE) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/planar_twist_integrator_core.sv */
`timescale 1ns / 1ps

// Pipelined planar twist integrator (SE(2) exponential map). One word is accepted every
// clock; in_ready drops only while both the output register and its skid stage hold
// words that the consumer has not taken. The number of angle range-reduction stages, KB,
// is 2 for FRAC_BITS of 17 and above and 18 - FRAC_BITS below that.
// The depth is set by one stage per CORDIC step and by the 33-stage restoring divider.

module planar_twist_integrator_core
  import ptwi_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int SH     = 30 - FRAC_BITS;
  localparam int MAG_W  = 20 + SH;
  localparam int RW     = ((MAG_W > 33) ? MAG_W : 33) + 1;
  localparam int KB     = (MAG_W > 33) ? MAG_W - 32 : 2;
  localparam int NS     = CORDIC_STEPS;
  localparam int P_FOLD = KB + 1;
  localparam int P_POST = P_FOLD + NS + 1;
  localparam int P_MUL  = P_POST + 1;
  localparam int P_SUM  = P_MUL + 1;
  localparam int P_MAG  = P_SUM + 1;
  localparam int P_LAST = P_MAG + QUO_W + 1;

  localparam logic [RW-1:0] TWO_PI_W = RW'(Q30_TWO_PI);
  localparam logic [RW-1:0] PI_W     = RW'(Q30_PI);

  logic        en;
  logic [15:0] band_r;

  logic vld_r [0:P_LAST];
  ctx_t ctx_r [0:P_LAST];

  logic [RW-1:0] red_r [0:KB];

  logic signed [33:0] ang_r  [0:NS];
  logic signed [33:0] x_r    [0:NS];
  logic signed [33:0] y_r    [0:NS];
  logic               fneg_r [0:NS];

  logic signed [31:0] s_r;
  logic signed [31:0] cm1_r;
  logic signed [32:0] omc_r;

  logic signed [63:0] pxs_r, pycm_r, pys_r, pxo_r;
  logic signed [63:0] nx_r, ny_r;

  logic [63:0]      drx_r [0:QUO_W+1];
  logic [63:0]      dry_r [0:QUO_W+1];
  logic [QUO_W-1:0] dqx_r [0:QUO_W+1];
  logic [QUO_W-1:0] dqy_r [0:QUO_W+1];
  logic             dox_r [0:QUO_W+1];
  logic             doy_r [0:QUO_W+1];
  logic             dnx_r [0:QUO_W+1];
  logic             dny_r [0:QUO_W+1];
  logic [MAG_W-1:0] dd_r  [0:QUO_W+1];

  logic      out_valid_r, skid_vld_r;
  out_word_t out_data_r, skid_data_r, fin_nxt;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
    end else if (cfg_we) begin
      band_r <= cfg_wdata;
    end
  end

  // Input stage: band check and start of the angle reduction.
  logic [19:0]      wmag_in;
  logic [MAG_W-1:0] dmag_in;
  ctx_t             ctx_nxt;

  always_comb begin
    wmag_in = in_data.ang_rate[19] ? (~in_data.ang_rate + 20'd1) : in_data.ang_rate;
    dmag_in = {wmag_in, {SH{1'b0}}};
    ctx_nxt.zone = (wmag_in <= {4'd0, band_r});
    ctx_nxt.tw   = in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_nxt;
      red_r[0] <= RW'(dmag_in) + PI_W;
    end
  end

  genvar gk;
  for (gk = 1; gk <= P_LAST; gk++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gk] <= 1'b0;
      end else if (en) begin
        vld_r[gk] <= vld_r[gk-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[gk] <= ctx_r[gk-1];
      end
    end
  end

  // Magnitude plus a half turn, reduced modulo a full turn by power-of-two multiples, largest first.
  genvar gj;
  for (gj = 1; gj <= KB; gj++) begin : g_red
    localparam logic [RW-1:0] STEP = TWO_PI_W << (KB - gj);
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[gj] <= (red_r[gj-1] >= STEP) ? red_r[gj-1] - STEP : red_r[gj-1];
      end
    end
  end

  // Fold into the right half plane; a half turn negates sine and cosine.
  logic signed [33:0] a_base, a_sgn;

  always_comb begin
    a_base = $signed({1'b0, red_r[KB][32:0]}) - Q30_PI;
    a_sgn  = ctx_r[KB].tw.ang_rate[19] ? -a_base : a_base;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      if (a_sgn > Q30_HALF_PI) begin
        ang_r[0]  <= a_sgn - Q30_PI;
        fneg_r[0] <= 1'b1;
      end else if (a_sgn < -Q30_HALF_PI) begin
        ang_r[0]  <= a_sgn + Q30_PI;
        fneg_r[0] <= 1'b1;
      end else begin
        ang_r[0]  <= a_sgn;
        fneg_r[0] <= 1'b0;
      end
    end
  end

  genvar gi;
  for (gi = 1; gi <= NS; gi++) begin : g_cordic
    logic signed [33:0] dx, dy, at;
    assign dx = x_r[gi-1] >>> (gi - 1);
    assign dy = y_r[gi-1] >>> (gi - 1);
    assign at = $signed({2'b00, atan_q30(5'(gi - 1))});
    always_ff @(posedge clk) begin
      if (en) begin
        fneg_r[gi] <= fneg_r[gi-1];
        if (!ang_r[gi-1][33]) begin
          x_r[gi]   <= x_r[gi-1] - dy;
          y_r[gi]   <= y_r[gi-1] + dx;
          ang_r[gi] <= ang_r[gi-1] - at;
        end else begin
          x_r[gi]   <= x_r[gi-1] + dy;
          y_r[gi]   <= y_r[gi-1] - dx;
          ang_r[gi] <= ang_r[gi-1] + at;
        end
      end
    end
  end

  logic signed [31:0] cos_nxt, sin_nxt;

  always_comb begin
    cos_nxt = clamp_unit(fneg_r[NS] ? -x_r[NS] : x_r[NS]);
    sin_nxt = clamp_unit(fneg_r[NS] ? -y_r[NS] : y_r[NS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= sin_nxt;
      cm1_r <= cos_nxt - 32'sd1073741824;
      omc_r <= 33'sd1073741824 - 33'(cos_nxt);
    end
  end

  logic signed [64:0] pxo_full;
  assign pxo_full = $signed(ctx_r[P_MUL-1].tw.lin_x) * omc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxs_r  <= $signed(ctx_r[P_MUL-1].tw.lin_x) * s_r;
      pycm_r <= $signed(ctx_r[P_MUL-1].tw.lin_y) * cm1_r;
      pys_r  <= $signed(ctx_r[P_MUL-1].tw.lin_y) * s_r;
      pxo_r  <= pxo_full[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= pxs_r + pycm_r;
      ny_r <= pys_r + pxo_r;
    end
  end

  // Magnitudes with half the divisor added, for round to nearest.
  logic [19:0]      wmag_m;
  logic [MAG_W-1:0] dmag_m;
  logic             wneg_m;
  logic [63:0]      nmx, nmy;

  always_comb begin
    wneg_m = ctx_r[P_MAG-1].tw.ang_rate[19];
    wmag_m = wneg_m ? (~ctx_r[P_MAG-1].tw.ang_rate + 20'd1) : ctx_r[P_MAG-1].tw.ang_rate;
    dmag_m = {wmag_m, {SH{1'b0}}};
    nmx    = nx_r[63] ? (~nx_r + 64'd1) : nx_r;
    nmy    = ny_r[63] ? (~ny_r + 64'd1) : ny_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drx_r[0] <= nmx + 64'(dmag_m >> 1);
      dry_r[0] <= nmy + 64'(dmag_m >> 1);
      dnx_r[0] <= nx_r[63] ^ wneg_m;
      dny_r[0] <= ny_r[63] ^ wneg_m;
      dd_r[0]  <= dmag_m;
      dqx_r[0] <= '0;
      dqy_r[0] <= '0;
      dox_r[0] <= 1'b0;
      doy_r[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drx_r[1] <= drx_r[0];
      dry_r[1] <= dry_r[0];
      dnx_r[1] <= dnx_r[0];
      dny_r[1] <= dny_r[0];
      dd_r[1]  <= dd_r[0];
      dqx_r[1] <= dqx_r[0];
      dqy_r[1] <= dqy_r[0];
      dox_r[1] <= (drx_r[0] >> QUO_W) >= 64'(dd_r[0]);
      doy_r[1] <= (dry_r[0] >> QUO_W) >= 64'(dd_r[0]);
    end
  end

  genvar gq;
  for (gq = 2; gq <= QUO_W + 1; gq++) begin : g_div
    localparam int BIT = QUO_W + 1 - gq;
    logic gex, gey;
    assign gex = (drx_r[gq-1] >> BIT) >= 64'(dd_r[gq-1]);
    assign gey = (dry_r[gq-1] >> BIT) >= 64'(dd_r[gq-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        drx_r[gq] <= gex ? drx_r[gq-1] - (64'(dd_r[gq-1]) << BIT) : drx_r[gq-1];
        dry_r[gq] <= gey ? dry_r[gq-1] - (64'(dd_r[gq-1]) << BIT) : dry_r[gq-1];
        dqx_r[gq] <= {dqx_r[gq-1][QUO_W-2:0], gex};
        dqy_r[gq] <= {dqy_r[gq-1][QUO_W-2:0], gey};
        dnx_r[gq] <= dnx_r[gq-1];
        dny_r[gq] <= dny_r[gq-1];
        dox_r[gq] <= dox_r[gq-1];
        doy_r[gq] <= doy_r[gq-1];
        dd_r[gq]  <= dd_r[gq-1];
      end
    end
  end

  logic             satx, saty, nx_f, ny_f;
  logic [QUO_W-1:0] qx, qy, qxn, qyn;
  logic [31:0]      vx_f, vy_f;

  always_comb begin
    nx_f = dnx_r[QUO_W+1];
    ny_f = dny_r[QUO_W+1];
    qx   = dqx_r[QUO_W+1];
    qy   = dqy_r[QUO_W+1];
    qxn  = ~qx + 1'b1;
    qyn  = ~qy + 1'b1;
    satx = dox_r[QUO_W+1] || (!nx_f && qx > POS_LIM) || (nx_f && qx > NEG_LIM);
    saty = doy_r[QUO_W+1] || (!ny_f && qy > POS_LIM) || (ny_f && qy > NEG_LIM);
    vx_f = satx ? (nx_f ? 32'h8000_0000 : 32'h7FFF_FFFF) : (nx_f ? qxn[31:0] : qx[31:0]);
    vy_f = saty ? (ny_f ? 32'h8000_0000 : 32'h7FFF_FFFF) : (ny_f ? qyn[31:0] : qy[31:0]);
    fin_nxt.heading = ctx_r[P_LAST].tw.ang_rate;
    if (ctx_r[P_LAST].zone) begin
      fin_nxt.disp_x  = ctx_r[P_LAST].tw.lin_x;
      fin_nxt.disp_y  = ctx_r[P_LAST].tw.lin_y;
      fin_nxt.clipped = 1'b0;
    end else begin
      fin_nxt.disp_x  = vx_f;
      fin_nxt.disp_y  = vy_f;
      fin_nxt.clipped = satx || saty;
    end
  end

  logic arrive, take;
  assign arrive = en && vld_r[P_LAST];
  assign take   = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_vld_r) begin
        out_valid_r <= 1'b1;
        skid_vld_r  <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_data_r <= skid_vld_r ? skid_data_r : fin_nxt;
    end else if (arrive) begin
      skid_data_r <= fin_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled while output was free");

  a_skid_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && vld_r[P_LAST]) |=> vld_r[P_LAST])
    else $error("word lost from pipeline tail during stall");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.clipped) |->
      (out_data_r.disp_x == 32'sh7FFF_FFFF || out_data_r.disp_x == 32'sh8000_0000 ||
       out_data_r.disp_y == 32'sh7FFF_FFFF || out_data_r.disp_y == 32'sh8000_0000))
    else $error("clipped set without a saturated displacement");

endmodule
